/* src/gbd_pkg.sv */
// Package for the geohash bounding-box decoder.
// Widths, status codes, payload structs and the base-32 symbol lookup.
// No dependencies.
`timescale 1ns / 1ps
package gbd_pkg;

	localparam int MAX_CHARS = 7;
	localparam int LON_W     = (5 * MAX_CHARS + 1) / 2;
	localparam int LAT_W     = (5 * MAX_CHARS) / 2;
	localparam int CNT_W     = $clog2(MAX_CHARS + 1);
	localparam int TOT_W     = $clog2(5 * MAX_CHARS + 2);

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	typedef struct packed {
		logic [7:0] symbol;
		logic       final_char;
	} sym_t;

	typedef struct packed {
		logic signed [40:0] lon_west;
		logic signed [39:0] lat_south;
		logic signed [40:0] lon_east;
		logic signed [39:0] lat_north;
		logic [1:0]         status;
	} box_t;

	typedef struct packed {
		logic [LON_W-1:0] lon;
		logic [LAT_W-1:0] lat;
		logic [CNT_W-1:0] count;
		logic [1:0]       err;
	} cell_t;

	typedef struct packed {
		logic       ok;
		logic [4:0] value;
	} lookup_t;

	function automatic lookup_t sym_lookup(input logic [7:0] c);
		lookup_t r;
		r.ok = 1'b1;
		unique case (c)
			8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
			8'h35, 8'h36, 8'h37, 8'h38, 8'h39: r.value = 5'(c - 8'h30);
			8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68: r.value = 5'(c - 8'h58);
			8'h6a, 8'h6b: r.value = 5'(c - 8'h59);
			8'h6d, 8'h6e: r.value = 5'(c - 8'h5a);
			8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75,
			8'h76, 8'h77, 8'h78, 8'h79, 8'h7a: r.value = 5'(c - 8'h5b);
			default: begin
				r.ok    = 1'b0;
				r.value = 5'd0;
			end
		endcase
		return r;
	endfunction

endpackage

/* src/gbd_accum.sv */
// Input stage: symbol lookup, bit interleave into lon/lat accumulators,
// length and error tracking; hands the finished cell to the box stage.
// Depends on gbd_pkg.
`timescale 1ns / 1ps
module gbd_accum import gbd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  sym_valid,
	output logic  sym_ready,
	input  sym_t  sym_data,
	input  logic  advance,
	output logic  cell_valid_s1,
	output cell_t cell_s1
);

	logic [LON_W-1:0] lon_q, lon_n;
	logic [LAT_W-1:0] lat_q, lat_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [1:0]       err_q, err_n;
	logic             too_long, accept;
	lookup_t          lk;
	logic [4:0]       b;

	assign sym_ready = !cell_valid_s1 || advance;
	assign accept    = sym_valid && sym_ready;
	assign too_long  = cnt_q >= CNT_W'(MAX_CHARS);
	assign lk        = sym_lookup(sym_data.symbol);
	assign b         = lk.ok ? lk.value : 5'd0;

	always_comb begin
		lon_n = lon_q;
		lat_n = lat_q;
		cnt_n = cnt_q;
		err_n = err_q;
		if (too_long) begin
			err_n = ST_TOO_LONG;
		end else begin
			if (!lk.ok && err_q == ST_OK) begin
				err_n = ST_BAD_CHAR;
			end
			// even bit positions feed longitude
			if (!cnt_q[0]) begin
				lon_n = LON_W'({lon_q, b[4], b[2], b[0]});
				lat_n = LAT_W'({lat_q, b[3], b[1]});
			end else begin
				lon_n = LON_W'({lon_q, b[3], b[1]});
				lat_n = LAT_W'({lat_q, b[4], b[2], b[0]});
			end
			cnt_n = cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lon_q         <= '0;
			lat_q         <= '0;
			cnt_q         <= '0;
			err_q         <= ST_OK;
			cell_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (sym_data.final_char) begin
					lon_q <= '0;
					lat_q <= '0;
					cnt_q <= '0;
					err_q <= ST_OK;
				end else begin
					lon_q <= lon_n;
					lat_q <= lat_n;
					cnt_q <= cnt_n;
					err_q <= err_n;
				end
			end
			if (accept && sym_data.final_char) begin
				cell_valid_s1 <= 1'b1;
			end else if (advance) begin
				cell_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && sym_data.final_char) begin
			cell_s1.lon   <= lon_n;
			cell_s1.lat   <= lat_n;
			cell_s1.count <= cnt_n;
			cell_s1.err   <= err_n;
		end
	end

endmodule

/* src/gbd_box.sv */
// Box stage: aligns the accumulated bits, scales to 2^-32 degree fixed point
// and loads the result register. Depends on gbd_pkg.
`timescale 1ns / 1ps
module gbd_box import gbd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cell_valid_s1,
	input  cell_t cell_s1,
	output logic  advance,
	output logic  box_valid,
	input  logic  box_ready,
	output box_t  box_data
);

	logic [TOT_W-1:0] tot, xl, yl;
	logic [LON_W-1:0] lon_al;
	logic [LAT_W-1:0] lat_al;
	logic [40:0]      west, east, lon_step;
	logic [39:0]      south, north, lat_step;
	logic             fail;
	box_t             box_n;

	assign advance = !box_valid || box_ready;

	assign tot    = TOT_W'(cell_s1.count) * TOT_W'(5);
	assign xl     = (tot + 1'b1) >> 1;
	assign yl     = tot >> 1;
	assign lon_al = cell_s1.lon << (TOT_W'(LON_W) - xl);
	assign lat_al = cell_s1.lat << (TOT_W'(LAT_W) - yl);

	assign west     = ((41'(lon_al) * 41'd360) << (32 - LON_W)) - (41'd180 << 32);
	assign south    = ((40'(lat_al) * 40'd180) << (32 - LAT_W)) - (40'd90 << 32);
	assign lon_step = 41'd360 << (6'd32 - 6'(xl));
	assign lat_step = 40'd180 << (6'd32 - 6'(yl));
	assign east     = west + lon_step;
	assign north    = south + lat_step;

	assign fail = (cell_s1.err != ST_OK) || (cell_s1.count == '0);

	always_comb begin
		if (fail) begin
			box_n.lon_west  = '0;
			box_n.lat_south = '0;
			box_n.lon_east  = '0;
			box_n.lat_north = '0;
		end else begin
			box_n.lon_west  = west;
			box_n.lat_south = south;
			box_n.lon_east  = east;
			box_n.lat_north = north;
		end
		box_n.status = cell_s1.err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_valid <= 1'b0;
		end else if (advance) begin
			box_valid <= cell_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cell_valid_s1) begin
			box_data <= box_n;
		end
	end

endmodule

/* src/geohash_bbox_decoder_top.sv */
// Geohash bounding-box decoder, top level.
// Path: the final character's transfer loads cell_s1; gbd_box then registers
// box_valid and box_data from it whenever the output side can advance.
// Throughput: one character per cycle, held off only while box_valid && !box_ready.
// Reset: arst_n clears accumulators, count, status and both valid flags at once.
// Depends on gbd_pkg, gbd_accum, gbd_box.
`timescale 1ns / 1ps
module geohash_bbox_decoder_top import gbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic sym_valid,
	output logic sym_ready,
	input  sym_t sym_data,
	output logic box_valid,
	input  logic box_ready,
	output box_t box_data
);

	logic  advance;
	logic  cell_valid_s1;
	cell_t cell_s1;

	gbd_accum u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.sym_valid     (sym_valid),
		.sym_ready     (sym_ready),
		.sym_data      (sym_data),
		.advance       (advance),
		.cell_valid_s1 (cell_valid_s1),
		.cell_s1       (cell_s1)
	);

	gbd_box u_box (
		.clk           (clk),
		.arst_n        (arst_n),
		.cell_valid_s1 (cell_valid_s1),
		.cell_s1       (cell_s1),
		.advance       (advance),
		.box_valid     (box_valid),
		.box_ready     (box_ready),
		.box_data      (box_data)
	);

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sym_ready |-> (box_valid && !box_ready))
		else $error("input stalled while output side can move");

	a_error_box_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(box_valid && box_data.status != ST_OK) |->
		(box_data.lon_west == '0 && box_data.lon_east == '0 &&
		 box_data.lat_south == '0 && box_data.lat_north == '0))
		else $error("error result carries a nonzero box");

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(box_valid && box_data.status == ST_OK) |->
		(box_data.lon_east > box_data.lon_west && box_data.lat_north > box_data.lat_south))
		else $error("box edges out of order");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |-> (box_data.status == ST_OK || box_data.status == ST_BAD_CHAR ||
		               box_data.status == ST_TOO_LONG))
		else $error("undefined status code");

endmodule

/* test/tb.sv */
// Testbench for geohash_bbox_decoder_top: drives geohash strings with random gaps and
// stalls, predicts each bounding box and status, and compares every box transfer.
// Depends on gbd_pkg and the decoder RTL.
`timescale 1ns / 1ps
module tb;
	import gbd_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_CHARS = 450;
	localparam logic [8*32-1:0] GEO_ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

	logic clk;
	logic arst_n;
	logic sym_valid;
	logic sym_ready;
	sym_t sym_data;
	logic box_valid;
	logic box_ready;
	box_t box_data;

	// predictor state
	logic [LON_W-1:0] lon_bits;
	logic [LAT_W-1:0] lat_bits;
	int               char_cnt;
	logic [1:0]       pend_status;
	box_t             boxes_due[$];

	box_t due_box;
	bit   steady;
	int   hold_len;
	int   hold_go;
	int   hold_taken;
	int   hold_left;
	int   errors;
	int   chars_sent;
	int   boxes_checked;
	int   n_ok, n_bad, n_long;
	int   idle_cycles;

	geohash_bbox_decoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_ready (sym_ready),
		.sym_data  (sym_data),
		.box_valid (box_valid),
		.box_ready (box_ready),
		.box_data  (box_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int geo_index(logic [7:0] c);
		for (int k = 0; k < 32; k++) begin
			if (GEO_ALPHABET[8*(31-k) +: 8] == c)
				return k;
		end
		return -1;
	endfunction

	function automatic logic [7:0] geo_char(int k);
		return GEO_ALPHABET[8*(31-k) +: 8];
	endfunction

	function automatic void clear_cell();
		lon_bits    = '0;
		lat_bits    = '0;
		char_cnt    = 0;
		pend_status = ST_OK;
	endfunction

	function automatic void absorb_symbol(sym_t s);
		int          v;
		int          pos;
		int          total, xl, yl;
		logic [4:0]  bits;
		logic [63:0] xs, ys, w, e, so, no;
		box_t        b;
		if (char_cnt >= MAX_CHARS) begin
			pend_status = ST_TOO_LONG;
		end else begin
			v = geo_index(s.symbol);
			if (v < 0) begin
				bits = 5'd0;
				if (pend_status == ST_OK)
					pend_status = ST_BAD_CHAR;
			end else begin
				bits = 5'(v);
			end
			for (int i = 4; i >= 0; i--) begin
				pos = 5 * char_cnt + (4 - i);
				if (pos % 2 == 0)
					lon_bits = {lon_bits[LON_W-2:0], bits[i]};
				else
					lat_bits = {lat_bits[LAT_W-2:0], bits[i]};
			end
			char_cnt++;
		end
		if (!s.final_char)
			return;
		b = '0;
		b.status = pend_status;
		if (pend_status == ST_OK) begin
			total = 5 * char_cnt;
			xl = (total + 1) / 2;
			yl = total / 2;
			xs = 64'd360 << (32 - xl);
			ys = 64'd180 << (32 - yl);
			w  = 64'(lon_bits) * xs - (64'd180 << 32);
			e  = (64'(lon_bits) + 64'd1) * xs - (64'd180 << 32);
			so = 64'(lat_bits) * ys - (64'd90 << 32);
			no = (64'(lat_bits) + 64'd1) * ys - (64'd90 << 32);
			b.lon_west  = w[40:0];
			b.lon_east  = e[40:0];
			b.lat_south = so[39:0];
			b.lat_north = no[39:0];
		end
		boxes_due = {boxes_due, b};
		clear_cell();
	endfunction

	function automatic void check_field(string name, logic signed [40:0] exp,
			logic signed [40:0] act);
		if (exp !== act) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && box_valid && box_ready) begin
			if (boxes_due.size() == 0) begin
				$error("box transfer with no string pending");
				errors++;
			end else begin
				due_box = boxes_due.pop_front();
				check_field("lon_west", due_box.lon_west, box_data.lon_west);
				check_field("lat_south", 41'(due_box.lat_south), 41'(box_data.lat_south));
				check_field("lon_east", due_box.lon_east, box_data.lon_east);
				check_field("lat_north", 41'(due_box.lat_north), 41'(box_data.lat_north));
				check_field("status", 41'(due_box.status), 41'(box_data.status));
				boxes_checked++;
				case (due_box.status)
					ST_OK:       n_ok++;
					ST_BAD_CHAR: n_bad++;
					default:     n_long++;
				endcase
			end
		end
	end

	always @(negedge clk) begin
		if (hold_go != hold_taken) begin
			hold_left  = hold_len;
			hold_taken = hold_go;
		end
		if (hold_left != 0) begin
			box_ready <= 1'b0;
			hold_left--;
		end else if (steady) begin
			box_ready <= 1'b1;
		end else begin
			box_ready <= ($urandom_range(99) >= 31);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((sym_valid && sym_ready) || (box_valid && box_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_sym(input logic [7:0] c, input logic fin);
		while (!steady && $urandom_range(99) < 31) begin
			sym_valid <= 1'b0;
			@(negedge clk);
		end
		sym_valid <= 1'b1;
		sym_data  <= {c, fin};
		@(posedge clk);
		while (!sym_ready)
			@(posedge clk);
		absorb_symbol(sym_data);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_geohash(input string s);
		for (int i = 0; i < s.len(); i++)
			send_sym(s[i], i == s.len() - 1);
	endtask

	task automatic wait_boxes_done();
		sym_valid <= 1'b0;
		while (boxes_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_extremes();
		send_geohash("0");
		send_geohash("z");
		send_geohash("zzzzzzz");
		send_geohash("00");
	endtask

	task automatic test_bad_symbols();
		send_geohash("A");
		send_sym(8'h00, 1'b0);
		send_sym(8'hff, 1'b1);
		send_geohash("9a");
	endtask

	// overlong string with a bad symbol inside: length error wins
	task automatic test_too_long();
		send_geohash("i0000000");
	endtask

	task automatic test_streaming();
		int len;
		steady = 1'b1;
		repeat (12) begin
			len = $urandom_range(1, MAX_CHARS);
			for (int i = 0; i < len; i++)
				send_sym(geo_char($urandom_range(31)), i == len - 1);
		end
		steady = 1'b0;
	endtask

	task automatic test_backpressure();
		hold_len = 150;
		hold_go++;
		repeat (40)
			send_sym(geo_char($urandom_range(31)), 1'b1);
	endtask

	task automatic test_drain_pause();
		send_geohash("u4pruyd");
		send_geohash("s");
		wait_boxes_done();
		repeat ($urandom_range(3, 12)) @(negedge clk);
		send_geohash("ezs42");
	endtask

	task automatic test_random();
		int stop_at;
		int kind;
		int len;
		int bad_pos;
		logic [7:0] c;
		stop_at = chars_sent + RANDOM_CHARS;
		while (chars_sent < stop_at) begin
			kind = $urandom_range(99);
			if (kind < 90) begin
				if (kind < 80 && kind >= 70)
					len = $urandom_range(MAX_CHARS + 1, MAX_CHARS + 3);
				else
					len = $urandom_range(1, MAX_CHARS);
				bad_pos = (kind >= 80) ? $urandom_range(len - 1) : -1;
				for (int i = 0; i < len; i++) begin
					c = (i == bad_pos) ? 8'($urandom_range(255)) : geo_char($urandom_range(31));
					send_sym(c, i == len - 1);
				end
			end else begin
				send_sym(8'($urandom_range(255)), 1'($urandom_range(1)));
			end
		end
		// close any string left open by noise
		send_sym(geo_char($urandom_range(31)), 1'b1);
	endtask

	initial begin
		arst_n        = 1'b0;
		sym_valid     = 1'b0;
		sym_data      = '0;
		steady        = 1'b0;
		chars_sent    = 0;
		clear_cell();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_extremes();
		test_bad_symbols();
		test_too_long();
		test_streaming();
		test_backpressure();
		test_drain_pause();
		test_random();

		sym_valid <= 1'b0;
		while (boxes_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (boxes_due.size() != 0)
			$error("%0d boxes never arrived", boxes_due.size());
		$display("summary: %0d characters sent, %0d boxes checked", chars_sent, boxes_checked);
		$display("summary: %0d ok, %0d bad symbol, %0d overlong, %0d mismatches",
			n_ok, n_bad, n_long, errors);
		if (errors == 0 && boxes_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
